>>> rtl/first_fit_segment_allocator_unit_assert.svh
// Assertion macros used by the allocator datapath.
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_UNIT_ASSERT_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_UNIT_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define FFSA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define FFSA_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

>>> rtl/ffsa_pkg.sv
// Types, constants and codes of the first-fit segment allocator.
package ffsa_pkg;

  localparam int ADDR_W     = 16;
  localparam int SIZE_W     = ADDR_W + 1;
  localparam int END_W      = SIZE_W + 1;
  localparam int MAX_SEG    = 64;
  localparam int IDX_W      = $clog2(MAX_SEG);
  localparam int CNT_W      = IDX_W + 1;
  localparam int HDR_BYTES  = 16;
  localparam int HDR_IDX_W  = ADDR_W - 3;
  localparam int HDR_DEPTH  = 1 << HDR_IDX_W;
  localparam int ADJ_W      = 8;
  localparam int REC_W      = ADJ_W + SIZE_W;
  localparam int LG_W       = 3;
  localparam int ALIGN_W    = 9;
  localparam int REQ_W      = 16;
  localparam int ST_W       = 2;
  localparam int IN_W       = 40;
  localparam int OUT_W      = 40;

  localparam int IN_REQ_LSB  = 0;
  localparam int IN_LG_LSB   = IN_REQ_LSB + REQ_W;
  localparam int IN_ADDR_LSB = IN_LG_LSB + LG_W;

  localparam logic [LG_W-1:0]   LG_MIN     = LG_W'(3);
  localparam logic [SIZE_W-1:0] POOL_MIN   = SIZE_W'(16);
  localparam logic [SIZE_W-1:0] POOL_LIMIT = SIZE_W'(1) << ADDR_W;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_ASCAN, S_FHDR, S_FSCAN, S_SHDN, S_SHUP, S_FIN
  } state_e;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_INIT, CMD_LOAD, CMD_HDR,
    CMD_A_NEXT, CMD_A_FAIL, CMD_A_SPLIT, CMD_A_TAKE,
    CMD_F_NEXT, CMD_F_BOTH, CMD_F_PREV, CMD_F_NEXTM, CMD_F_FULL, CMD_F_INS,
    CMD_DN_MOVE, CMD_DN_END, CMD_UP_MOVE, CMD_UP_END, CMD_PUSH
  } cmd_e;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [SIZE_W-1:0] bytes;
  } seg_t;

  typedef struct packed {
    logic cfg_seen;
    logic scan_end;
    logic fit;
    logic take;
    logic f_stop;
    logic prev_adj;
    logic next_adj;
    logic full;
    logic dn_more;
    logic up_more;
    logic out_free;
  } dp_stat_t;

endpackage

>>> rtl/first_fit_segment_allocator_unit.sv
// Top level of the first-fit segment allocator.
// Keeps up to 64 free segments of the pool in address order in a table memory and
// serves one allocate or free item at a time. An allocate scans the table for the first
// fit and, when a segment is used up, moves the entries above it down; a free scans the
// entries below the block and moves entries to close or open a table slot. The table
// walk reads one entry per cycle; a result that cannot enter a full output register
// waits until the register is free. After reset or a pool_size write the table is
// rebuilt. A finished result waits in the output register until taken.
module first_fit_segment_allocator_unit import ffsa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_wdata_i,    // pool_size
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_W-1:0]   s_axis_tdata,   // request_bytes, align_log2, free_address
  input  logic              s_axis_tuser,   // func
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_W-1:0]  m_axis_tdata    // user_address, block_bytes, status
);

  dp_stat_t stat;
  cmd_e     cmd;

  ffsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stat_i      (stat),
    .in_tvalid_i (s_axis_tvalid),
    .in_func_i   (s_axis_tuser),
    .in_tready_o (s_axis_tready),
    .cmd_o       (cmd)
  );

  ffsa_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_tdata_i   (s_axis_tdata),
    .cmd_i        (cmd),
    .out_tready_i (m_axis_tready),
    .stat_o       (stat),
    .out_tvalid_o (m_axis_tvalid),
    .out_tdata_o  (m_axis_tdata)
  );

endmodule

>>> rtl/ffsa_datapath.sv
// Datapath of the allocator: segment table, header store, arithmetic, result register.
`include "first_fit_segment_allocator_unit_assert.svh"
module ffsa_datapath import ffsa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_wdata_i,
  input  logic [IN_W-1:0]   in_tdata_i,
  input  cmd_e              cmd_i,
  input  logic              out_tready_i,
  output dp_stat_t          stat_o,
  output logic              out_tvalid_o,
  output logic [OUT_W-1:0]  out_tdata_o
);

  seg_t                tab_mem [MAX_SEG];
  logic [REC_W-1:0]    hdr_mem [HDR_DEPTH];
  seg_t                tab_rd_q;
  logic [REC_W-1:0]    hdr_rd_q;

  logic [SIZE_W-1:0]   pool_q;
  logic [CNT_W-1:0]    cnt_q, idx_q, j_q;
  logic                out_valid_q;
  logic [REQ_W-1:0]    req_q;
  logic [LG_W-1:0]     lg_q;
  logic [ADDR_W-1:0]   addr_q;
  seg_t                prev_q;
  logic [ADDR_W-1:0]   bstart_q;
  logic [SIZE_W-1:0]   size_q;
  logic [END_W-1:0]    bend_q;
  logic [ADDR_W-1:0]   res_user_q, out_user_q;
  logic [SIZE_W-1:0]   res_bytes_q, out_bytes_q;
  status_e             res_status_q, out_status_q;

  logic [IDX_W-1:0]     rd_addr, tab_wa;
  logic                 tab_we, hdr_we;
  seg_t                 tab_wd;
  logic [HDR_IDX_W-1:0] hdr_wa, hdr_ra;
  logic [REC_W-1:0]     hdr_wd;

  // allocate arithmetic on the entry under the scan pointer
  logic [LG_W-1:0]    lg_c;
  logic [ALIGN_W-1:0] align, mis, a0, need, adj;
  logic [SIZE_W-1:0]  total, rem, grant;
  logic [ADDR_W-1:0]  user;
  logic               fit;

  always_comb begin
    lg_c  = (lg_q < LG_MIN) ? LG_MIN : lg_q;
    align = ALIGN_W'(1) << lg_c;
    mis   = {1'b0, tab_rd_q.start[7:0]} & (align - ALIGN_W'(1));
    a0    = (mis != '0) ? align - mis : '0;
    need  = ALIGN_W'(HDR_BYTES) - a0;
    adj   = (a0 < ALIGN_W'(HDR_BYTES))
          ? a0 + (((need + align - ALIGN_W'(1)) >> lg_c) << lg_c) : a0;
    total = {1'b0, req_q} + SIZE_W'(adj);
    fit   = tab_rd_q.bytes >= total;
    rem   = tab_rd_q.bytes - total;
    grant = (rem <= SIZE_W'(HDR_BYTES)) ? tab_rd_q.bytes : total;
    user  = tab_rd_q.start + ADDR_W'(adj);
  end

  // free: header record of the returned block
  logic [SIZE_W-1:0] f_size;
  logic [ADJ_W-1:0]  f_adj;
  logic [ADDR_W-1:0] f_bstart;
  logic [END_W-1:0]  f_bend, prev_end, cur_start;

  assign f_size    = hdr_rd_q[SIZE_W-1:0];
  assign f_adj     = hdr_rd_q[REC_W-1:SIZE_W];
  assign f_bstart  = addr_q - ADDR_W'(f_adj);
  assign f_bend    = END_W'(f_bstart) + END_W'(f_size);
  assign prev_end  = END_W'(prev_q.start) + END_W'(prev_q.bytes);
  assign cur_start = END_W'(tab_rd_q.start);

  always_comb begin
    stat_o.cfg_seen = cfg_we_i;
    stat_o.scan_end = idx_q == cnt_q;
    stat_o.fit      = fit;
    stat_o.take     = rem <= SIZE_W'(HDR_BYTES);
    stat_o.f_stop   = (idx_q == cnt_q) || (cur_start >= bend_q);
    stat_o.prev_adj = (idx_q != '0) && (prev_end == END_W'(bstart_q));
    stat_o.next_adj = (idx_q != cnt_q) && (cur_start == bend_q);
    stat_o.full     = cnt_q >= CNT_W'(MAX_SEG);
    stat_o.dn_more  = (idx_q + CNT_W'(1)) < cnt_q;
    stat_o.up_more  = idx_q > j_q;
    stat_o.out_free = !out_valid_q || out_tready_i;
  end

  // memory port control
  always_comb begin
    rd_addr = '0;
    tab_we  = 1'b0;
    tab_wa  = idx_q[IDX_W-1:0];
    tab_wd  = tab_rd_q;
    hdr_we  = 1'b0;
    hdr_wa  = user[ADDR_W-1:3];
    hdr_wd  = {adj[ADJ_W-1:0], grant};
    hdr_ra  = in_tdata_i[IN_ADDR_LSB+3 +: HDR_IDX_W];
    unique case (cmd_i)
      CMD_INIT: begin
        tab_we = 1'b1;
        tab_wa = '0;
        tab_wd = '{start: '0, bytes: pool_q};
      end
      CMD_A_NEXT, CMD_F_NEXT: rd_addr = IDX_W'(idx_q + CNT_W'(1));
      CMD_A_SPLIT: begin
        tab_we = 1'b1;
        tab_wd = '{start: tab_rd_q.start + total[ADDR_W-1:0], bytes: rem};
        hdr_we = 1'b1;
      end
      CMD_A_TAKE: begin
        hdr_we  = 1'b1;
        rd_addr = IDX_W'(idx_q + CNT_W'(1));
      end
      CMD_F_BOTH: begin
        tab_we  = 1'b1;
        tab_wa  = IDX_W'(idx_q - CNT_W'(1));
        tab_wd  = '{start: prev_q.start,
                    bytes: SIZE_W'(prev_q.bytes + size_q + tab_rd_q.bytes)};
        rd_addr = IDX_W'(idx_q + CNT_W'(1));
      end
      CMD_F_PREV: begin
        tab_we = 1'b1;
        tab_wa = IDX_W'(idx_q - CNT_W'(1));
        tab_wd = '{start: prev_q.start, bytes: SIZE_W'(prev_q.bytes + size_q)};
      end
      CMD_F_NEXTM: begin
        tab_we = 1'b1;
        tab_wd = '{start: bstart_q, bytes: SIZE_W'(tab_rd_q.bytes + size_q)};
      end
      CMD_F_INS: rd_addr = IDX_W'(cnt_q - CNT_W'(1));
      CMD_DN_MOVE: begin
        tab_we  = 1'b1;
        rd_addr = IDX_W'(idx_q + CNT_W'(2));
      end
      CMD_UP_MOVE: begin
        tab_we  = 1'b1;
        rd_addr = IDX_W'(idx_q - CNT_W'(2));
      end
      CMD_UP_END: begin
        tab_we = 1'b1;
        tab_wa = j_q[IDX_W-1:0];
        tab_wd = '{start: bstart_q, bytes: size_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (tab_we) tab_mem[tab_wa] <= tab_wd;
    tab_rd_q <= tab_mem[rd_addr];
    if (hdr_we) hdr_mem[hdr_wa] <= hdr_wd;
    hdr_rd_q <= hdr_mem[hdr_ra];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q      <= POOL_LIMIT;
      cnt_q       <= CNT_W'(1);
      idx_q       <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_wdata_i < POOL_MIN)        pool_q <= POOL_MIN;
        else if (cfg_wdata_i > POOL_LIMIT) pool_q <= POOL_LIMIT;
        else                               pool_q <= cfg_wdata_i;
      end
      if (out_valid_q && out_tready_i && cmd_i != CMD_PUSH) out_valid_q <= 1'b0;
      unique case (cmd_i)
        CMD_INIT:                       cnt_q <= CNT_W'(1);
        CMD_LOAD, CMD_HDR:              idx_q <= '0;
        CMD_A_NEXT, CMD_F_NEXT,
        CMD_DN_MOVE:                    idx_q <= idx_q + CNT_W'(1);
        CMD_F_INS: begin
          j_q   <= idx_q;
          idx_q <= cnt_q;
        end
        CMD_DN_END:                     cnt_q <= cnt_q - CNT_W'(1);
        CMD_UP_MOVE:                    idx_q <= idx_q - CNT_W'(1);
        CMD_UP_END:                     cnt_q <= cnt_q + CNT_W'(1);
        CMD_PUSH:                       out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      CMD_LOAD: begin
        req_q  <= in_tdata_i[IN_REQ_LSB +: REQ_W];
        lg_q   <= in_tdata_i[IN_LG_LSB +: LG_W];
        addr_q <= in_tdata_i[IN_ADDR_LSB +: ADDR_W];
      end
      CMD_HDR: begin
        bstart_q <= f_bstart;
        size_q   <= f_size;
        bend_q   <= f_bend;
      end
      CMD_F_NEXT: prev_q <= tab_rd_q;
      CMD_A_FAIL: begin
        res_user_q   <= '0;
        res_bytes_q  <= '0;
        res_status_q <= ST_NOFIT;
      end
      CMD_A_SPLIT, CMD_A_TAKE: begin
        res_user_q   <= user;
        res_bytes_q  <= grant;
        res_status_q <= ST_OK;
      end
      CMD_F_BOTH, CMD_F_PREV, CMD_F_NEXTM, CMD_F_INS: begin
        res_user_q   <= '0;
        res_bytes_q  <= size_q;
        res_status_q <= ST_OK;
      end
      CMD_F_FULL: begin
        res_user_q   <= '0;
        res_bytes_q  <= '0;
        res_status_q <= ST_FULL;
      end
      CMD_PUSH: begin
        out_user_q   <= res_user_q;
        out_bytes_q  <= res_bytes_q;
        out_status_q <= res_status_q;
      end
      default: ;
    endcase
  end

  assign out_tvalid_o = out_valid_q;
  assign out_tdata_o  = {{(OUT_W - ADDR_W - SIZE_W - ST_W){1'b0}},
                         out_status_q, out_bytes_q, out_user_q};

  `FFSA_NEVER(a_cnt_range, clk_i, rst_ni, cnt_q > CNT_W'(MAX_SEG), "segment count overflow")
  `FFSA_ASSERT(a_push_valid, clk_i, rst_ni, cmd_i == CMD_PUSH |=> out_valid_q, "result lost")
  `FFSA_ASSERT(a_fail_zero, clk_i, rst_ni, (out_valid_q && out_status_q != ST_OK) |-> (out_bytes_q == '0 && out_user_q == '0), "failed result not zero")
  `FFSA_NEVER(a_push_busy, clk_i, rst_ni, cmd_i == CMD_PUSH && out_valid_q && !out_tready_i, "result overwritten")

endmodule

>>> rtl/ffsa_ctrl.sv
// Controller state machine of the allocator.
module ffsa_ctrl import ffsa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  dp_stat_t stat_i,
  input  logic     in_tvalid_i,
  input  logic     in_func_i,
  output logic     in_tready_o,
  output cmd_e     cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_INIT;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT: state_d = S_IDLE;
      S_IDLE: begin
        if (stat_i.cfg_seen)  state_d = S_INIT;
        else if (in_tvalid_i) state_d = in_func_i ? S_FHDR : S_ASCAN;
      end
      S_ASCAN: begin
        priority if (stat_i.scan_end)             state_d = S_FIN;
        else if (stat_i.fit && stat_i.take)       state_d = S_SHDN;
        else if (stat_i.fit)                      state_d = S_FIN;
        else                                      state_d = S_ASCAN;
      end
      S_FHDR: state_d = S_FSCAN;
      S_FSCAN: begin
        priority if (!stat_i.f_stop)                   state_d = S_FSCAN;
        else if (stat_i.prev_adj && stat_i.next_adj)   state_d = S_SHDN;
        else if (stat_i.prev_adj || stat_i.next_adj)   state_d = S_FIN;
        else if (stat_i.full)                          state_d = S_FIN;
        else                                           state_d = S_SHUP;
      end
      S_SHDN: if (!stat_i.dn_more) state_d = S_FIN;
      S_SHUP: if (!stat_i.up_more) state_d = S_FIN;
      S_FIN:  if (stat_i.out_free) state_d = S_IDLE;
      default: state_d = S_INIT;
    endcase
  end

  always_comb begin
    cmd_o       = CMD_NONE;
    in_tready_o = 1'b0;
    unique case (state_q)
      S_INIT: cmd_o = CMD_INIT;
      S_IDLE: begin
        in_tready_o = !stat_i.cfg_seen;
        if (in_tvalid_i && !stat_i.cfg_seen) cmd_o = CMD_LOAD;
      end
      S_ASCAN: begin
        priority if (stat_i.scan_end)       cmd_o = CMD_A_FAIL;
        else if (stat_i.fit && stat_i.take) cmd_o = CMD_A_TAKE;
        else if (stat_i.fit)                cmd_o = CMD_A_SPLIT;
        else                                cmd_o = CMD_A_NEXT;
      end
      S_FHDR: cmd_o = CMD_HDR;
      S_FSCAN: begin
        priority if (!stat_i.f_stop)                 cmd_o = CMD_F_NEXT;
        else if (stat_i.prev_adj && stat_i.next_adj) cmd_o = CMD_F_BOTH;
        else if (stat_i.prev_adj)                    cmd_o = CMD_F_PREV;
        else if (stat_i.next_adj)                    cmd_o = CMD_F_NEXTM;
        else if (stat_i.full)                        cmd_o = CMD_F_FULL;
        else                                         cmd_o = CMD_F_INS;
      end
      S_SHDN: cmd_o = stat_i.dn_more ? CMD_DN_MOVE : CMD_DN_END;
      S_SHUP: cmd_o = stat_i.up_more ? CMD_UP_MOVE : CMD_UP_END;
      S_FIN:  if (stat_i.out_free) cmd_o = CMD_PUSH;
      default: cmd_o = CMD_NONE;
    endcase
  end

endmodule

>>> sim/tb_first_fit_segment_allocator_unit.sv
// Self-checking testbench for the first-fit segment allocator unit.
module tb_first_fit_segment_allocator_unit;
  import ffsa_pkg::*;

  typedef enum logic [1:0] {ROW_ALLOC, ROW_FREE, ROW_CFG} row_kind_e;

  typedef struct packed {
    logic [ADDR_W-1:0] user;
    logic [SIZE_W-1:0] bytes;
    status_e           status;
  } grant_t;

  typedef struct {
    row_kind_e         kind;
    logic [REQ_W-1:0]  req;
    logic [LG_W-1:0]   lg;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] cfg;
    bit                typed;
    grant_t            want;
  } row_t;

  localparam int WATCHDOG = 4000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [SIZE_W-1:0] cfg_wdata_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata = '0;
  logic              s_axis_tuser = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;

  first_fit_segment_allocator_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // allocator mirror
  int unsigned   seg_base [MAX_SEG];
  int unsigned   seg_len [MAX_SEG];
  int unsigned   seg_cnt;
  int unsigned   hdr_rec [int unsigned];
  logic [ADDR_W-1:0] held [$];
  logic [ADDR_W-1:0] released [$];
  grant_t        grant_q [$];
  int            errors = 0;
  int            idle_cycles = 0;
  bit            quiet = 1'b0;

  function automatic void pool_reset(int unsigned v);
    v = v & 'h1FFFF;
    if (v < 16) v = 16;
    if (v > 65536) v = 65536;
    seg_cnt = 1;
    seg_base[0] = 0;
    seg_len[0] = v;
    held.delete();
    released.delete();
  endfunction

  function automatic void drop_seg(int unsigned i);
    for (int unsigned k = i; k + 1 < seg_cnt; k++) begin
      seg_base[k] = seg_base[k+1];
      seg_len[k] = seg_len[k+1];
    end
    seg_cnt--;
  endfunction

  function automatic grant_t alloc_model(int unsigned req, int unsigned lg);
    int unsigned align, mis, pad, total, user, b, n;
    grant_t g;
    if (lg < 3) lg = 3;
    align = 1 << lg;
    for (int unsigned i = 0; i < seg_cnt; i++) begin
      b = seg_base[i];
      n = seg_len[i];
      mis = b & (align - 1);
      pad = mis ? align - mis : 0;
      if (pad < HDR_BYTES) pad += ((HDR_BYTES - pad + align - 1) / align) * align;
      total = req + pad;
      if (n < total) continue;
      if (n - total <= HDR_BYTES) begin
        total = n;
        drop_seg(i);
      end else begin
        seg_base[i] = (b + total) & 'hFFFF;
        seg_len[i] = n - total;
      end
      user = (b + pad) & 'hFFFF;
      hdr_rec[user >> 3] = ((pad & 'hFF) << 17) | (total & 'h1FFFF);
      held.push_back(user[ADDR_W-1:0]);
      g.user = user[ADDR_W-1:0];
      g.bytes = total[SIZE_W-1:0];
      g.status = ST_OK;
      return g;
    end
    g.user = '0;
    g.bytes = '0;
    g.status = ST_NOFIT;
    return g;
  endfunction

  function automatic grant_t free_model(int unsigned addr);
    int unsigned rec, size, pad, bstart, j;
    longint unsigned bend;
    bit prev_touch, next_touch;
    grant_t g;
    rec = hdr_rec.exists(addr >> 3) ? hdr_rec[addr >> 3] : 0;
    size = rec & 'h1FFFF;
    pad = (rec >> 17) & 'hFF;
    bstart = (addr - pad) & 'hFFFF;
    bend = longint'(bstart) + size;
    j = 0;
    while (j < seg_cnt && longint'(seg_base[j]) < bend) j++;
    prev_touch = j > 0 && longint'(seg_base[j-1]) + seg_len[j-1] == bstart;
    next_touch = j < seg_cnt && longint'(seg_base[j]) == bend;
    g.user = '0;
    g.bytes = size[SIZE_W-1:0];
    g.status = ST_OK;
    if (prev_touch) begin
      seg_len[j-1] = (seg_len[j-1] + size) & 'h1FFFF;
      if (next_touch) begin
        seg_len[j-1] = (seg_len[j-1] + seg_len[j]) & 'h1FFFF;
        drop_seg(j);
      end
    end else if (next_touch) begin
      seg_base[j] = bstart;
      seg_len[j] = (seg_len[j] + size) & 'h1FFFF;
    end else if (seg_cnt >= MAX_SEG) begin
      g.bytes = '0;
      g.status = ST_FULL;
    end else begin
      for (int unsigned k = seg_cnt; k > j; k--) begin
        seg_base[k] = seg_base[k-1];
        seg_len[k] = seg_len[k-1];
      end
      seg_base[j] = bstart;
      seg_len[j] = size;
      seg_cnt++;
    end
    return g;
  endfunction

  task automatic report(string what, grant_t got, grant_t want);
    errors++;
    $display("mismatch %s: user %h/%h bytes %h/%h status %0d/%0d", what,
             got.user, want.user, got.bytes, want.bytes, got.status, want.status);
  endtask

  // result checker
  always @(posedge clk_i) begin
    grant_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got.user = m_axis_tdata[15:0];
      got.bytes = m_axis_tdata[32:16];
      got.status = status_e'(m_axis_tdata[34:33]);
      if (grant_q.size() == 0) begin
        report("unexpected item", got, got);
      end else begin
        want = grant_q.pop_front();
        if (got.user !== want.user) report("user_address", got, want);
        else if (got.bytes !== want.bytes) report("block_bytes", got, want);
        else if (got.status !== want.status) report("status", got, want);
      end
    end
  end

  // receiver stalls
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 99) < 12) begin
        n = $urandom_range(1, 9);
        m_axis_tready = 1'b0;
        repeat (n) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic drain();
    while (grant_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_pool(logic [SIZE_W-1:0] v);
    drain();
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    pool_reset(v);
  endtask

  // one item: gap, present, wait for accept, then predict
  task automatic send(bit fn, logic [REQ_W-1:0] req, logic [LG_W-1:0] lg,
                      logic [ADDR_W-1:0] addr, bit typed, grant_t want);
    grant_t g;
    int n;
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 99) < 15) begin
      n = $urandom_range(1, 9);
      s_axis_tvalid = 1'b0;
      repeat (n) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = fn;
    s_axis_tdata = '0;
    s_axis_tdata[15:0] = req;
    s_axis_tdata[18:16] = lg;
    s_axis_tdata[34:19] = addr;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    g = fn ? free_model(addr) : alloc_model(req, lg);
    grant_q.push_back(typed ? want : g);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic random_item(bit allow_double);
    int r, idx;
    logic [ADDR_W-1:0] a;
    grant_t none;
    none = '0;
    r = $urandom_range(0, 99);
    if (held.size() > 0 && r < 42) begin
      if (allow_double && released.size() > 0 && r < 2) begin
        a = released[$urandom_range(0, released.size() - 1)];
      end else begin
        idx = $urandom_range(0, held.size() - 1);
        a = held[idx];
        held.delete(idx);
        released.push_back(a);
      end
      send(1'b1, 16'($urandom), 3'($urandom), a, 1'b0, none);
    end else begin
      r = $urandom_range(0, 99);
      send(1'b0, r < 85 ? 16'($urandom_range(0, 700)) : 16'($urandom),
           3'($urandom_range(0, 7)), 16'($urandom), 1'b0, none);
    end
  endtask

  row_t rows [$];

  function automatic row_t mk(row_kind_e k, int req, int lg, int addr, int cfg,
                              bit typed, int u, int b, status_e st);
    row_t r;
    r.kind = k;
    r.req = REQ_W'(req);
    r.lg = LG_W'(lg);
    r.addr = ADDR_W'(addr);
    r.cfg = SIZE_W'(cfg);
    r.typed = typed;
    r.want.user = ADDR_W'(u);
    r.want.bytes = SIZE_W'(b);
    r.want.status = st;
    return r;
  endfunction

  initial begin
    logic [ADDR_W-1:0] frag [$];
    pool_reset(65536);
    // directed rows: extremes, padding corner cases, clamp, empty table
    rows.push_back(mk(ROW_ALLOC, 0, 3, 'hFFFF, 0, 1, 16, 16, ST_OK));
    rows.push_back(mk(ROW_ALLOC, 65535, 7, 0, 0, 1, 0, 0, ST_NOFIT));
    rows.push_back(mk(ROW_ALLOC, 1, 0, 0, 0, 0, 0, 0, ST_OK));
    rows.push_back(mk(ROW_ALLOC, 100, 7, 0, 0, 0, 0, 0, ST_OK));
    rows.push_back(mk(ROW_ALLOC, 37, 5, 0, 0, 0, 0, 0, ST_OK));
    rows.push_back(mk(ROW_ALLOC, 8, 2, 0, 0, 0, 0, 0, ST_OK));
    rows.push_back(mk(ROW_FREE, 'hFFFF, 7, 16, 0, 1, 0, 16, ST_OK));
    rows.push_back(mk(ROW_ALLOC, 65535, 3, 0, 0, 0, 0, 0, ST_OK));
    rows.push_back(mk(ROW_CFG, 0, 0, 0, 0, 0, 0, 0, ST_OK));
    rows.push_back(mk(ROW_ALLOC, 0, 3, 0, 0, 1, 16, 16, ST_OK));
    rows.push_back(mk(ROW_ALLOC, 0, 3, 0, 0, 1, 0, 0, ST_NOFIT));
    rows.push_back(mk(ROW_FREE, 0, 0, 16, 0, 1, 0, 16, ST_OK));
    rows.push_back(mk(ROW_ALLOC, 1, 4, 0, 0, 1, 0, 0, ST_NOFIT));
    rows.push_back(mk(ROW_CFG, 0, 0, 0, 'h1FFFF, 0, 0, 0, ST_OK));
    rows.push_back(mk(ROW_ALLOC, 65535, 7, 0, 0, 0, 0, 0, ST_OK));
    rows.push_back(mk(ROW_ALLOC, 0, 7, 0, 0, 0, 0, 0, ST_OK));
    rows.push_back(mk(ROW_FREE, 0, 0, 128, 0, 0, 0, 0, ST_OK));
    rows.push_back(mk(ROW_CFG, 0, 0, 0, 65536, 0, 0, 0, ST_OK));

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) write_pool(rows[i].cfg);
      else send(rows[i].kind == ROW_FREE, rows[i].req, rows[i].lg, rows[i].addr,
                rows[i].typed, rows[i].want);
    end

    repeat (170) random_item(1'b0);

    // fragment a small pool until the segment table overflows
    write_pool(SIZE_W'(4096));
    repeat (140) send(1'b0, 16'($urandom_range(0, 8)), 3'd3, 16'($urandom), 1'b0, '0);
    frag = held;
    for (int i = 1; i < frag.size(); i += 2)
      send(1'b1, 16'($urandom), 3'($urandom), frag[i], 1'b0, '0);

    write_pool(SIZE_W'(65536));
    repeat (110) random_item(1'b1);
    quiet = 1'b1;
    repeat (80) random_item(1'b1);

    drain();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
